/* rtl/rlwt_pkg.sv */
`default_nettype none

package rlwt_pkg;

    // Block capacity and derived widths
    localparam int MAX_INSTRS = 1024;
    localparam int POS_W      = $clog2(MAX_INSTRS);
    localparam int CNT_W      = $clog2(MAX_INSTRS + 1);
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);

    // Result field widths
    localparam int CLASS_W    = 2;
    localparam int DEST_W     = 7;
    localparam int PROD_W     = 11;
    localparam int POSF_W     = 10;
    localparam int DATA_IN_W  = 32;
    localparam int DATA_OUT_W = 48;

    // Operation classes
    localparam logic [CLASS_W-1:0] CLS_CONTROL = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_STORE   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_LOAD    = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_COMPUTE = 2'd3;

    // Major opcodes
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_LOAD_FP  = 7'h07;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_STORE_FP = 7'h27;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_FMADD    = 7'h43;
    localparam logic [6:0] OPC_FMSUB    = 7'h47;
    localparam logic [6:0] OPC_FNMSUB   = 7'h4B;
    localparam logic [6:0] OPC_FNMADD   = 7'h4F;
    localparam logic [6:0] OPC_OP_FP    = 7'h53;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_JAL      = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;

    // funct7 codes of FP ops that take an integer rs1
    localparam logic [6:0] F7_FMV_W_X   = 7'h78;
    localparam logic [6:0] F7_FCVT_S_W  = 7'h68;

    // Register usage of one instruction word
    typedef struct packed {
        logic [CLASS_W-1:0] op_class;
        logic               dest_used;
        logic [SLOT_W-1:0]  dest_slot;
        logic               rs1_used;
        logic [SLOT_W-1:0]  rs1_slot;
        logic               rs2_used;
        logic [SLOT_W-1:0]  rs2_slot;
    } dec_info_t;

    // Stored position to producer field (zero extend or truncate)
    function automatic logic [PROD_W-1:0] prod_field(input logic [POS_W-1:0] pos);
        logic [POS_W+PROD_W-1:0] tmp;
        tmp = '0;
        tmp[POS_W-1:0] = pos;
        return tmp[PROD_W-1:0];
    endfunction

    // Stored position to position field
    function automatic logic [POSF_W-1:0] pos_field(input logic [POS_W-1:0] pos);
        logic [POS_W+POSF_W-1:0] tmp;
        tmp = '0;
        tmp[POS_W-1:0] = pos;
        return tmp[POSF_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/rlwt_ram.sv */
`default_nettype none

module rlwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; a read that meets a write
    // to the same entry returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/rlwt_decode.sv */
`default_nettype none

module rlwt_decode import rlwt_pkg::*; (
    input  wire logic [DATA_IN_W-1:0] instruction,
    output dec_info_t                 info
);

    logic [6:0] opc;
    logic [6:0] f7;
    logic       fp_arith;
    logic       rs1_fp;
    logic       rs2_fp;
    logic       dest_fp;

    assign opc = instruction[6:0];
    assign f7  = instruction[31:25];

    assign fp_arith = (opc == OPC_OP_FP) || (opc == OPC_FMADD) || (opc == OPC_FMSUB)
                   || (opc == OPC_FNMSUB) || (opc == OPC_FNMADD);

    // Register file selection per operand
    assign rs1_fp  = fp_arith && (f7 != F7_FMV_W_X) && (f7 != F7_FCVT_S_W);
    assign rs2_fp  = (opc == OPC_STORE_FP) || fp_arith;
    assign dest_fp = (opc == OPC_LOAD_FP) || fp_arith;

    always_comb
    begin
        // Class by major opcode
        if ((opc == OPC_BRANCH) || (opc == OPC_JAL) || (opc == OPC_JALR)
            || (opc == OPC_SYSTEM))
        begin
            info.op_class = CLS_CONTROL;
        end
        else if ((opc == OPC_STORE) || (opc == OPC_STORE_FP))
        begin
            info.op_class = CLS_STORE;
        end
        else if ((opc == OPC_LOAD) || (opc == OPC_LOAD_FP))
        begin
            info.op_class = CLS_LOAD;
        end
        else
        begin
            info.op_class = CLS_COMPUTE;
        end

        // Operand usage and table slots (FP registers in the upper half)
        info.rs1_used  = (opc != OPC_LUI) && (opc != OPC_AUIPC) && (opc != OPC_JAL);
        info.rs1_slot  = {rs1_fp, instruction[19:15]};
        info.rs2_used  = (opc == OPC_OP) || (opc == OPC_STORE) || (opc == OPC_STORE_FP)
                      || (opc == OPC_BRANCH) || fp_arith;
        info.rs2_slot  = {rs2_fp, instruction[24:20]};
        info.dest_used = (opc != OPC_STORE) && (opc != OPC_STORE_FP) && (opc != OPC_BRANCH);
        info.dest_slot = {dest_fp, instruction[11:7]};
    end

endmodule

`default_nettype wire

/* rtl/register_last_writer_tracker.sv */
// Register last-writer tracker. Each input beat carries one RISC-V instruction
// word (tlast marks the final word of a code block); each output beat returns
// its class, destination slot (0-31 integer, 32-63 FP, -1 none), the block
// positions of the last writers of rs1 and rs2 (-1 none), its own position and
// an overflow flag. One word is accepted per cycle while the result stage is
// free or draining; the sources are read from two copies of a 64-entry position
// RAM (one read port each) while the destination is written back in the same
// cycle, with the old contents returned on a read that meets that write. Per-
// slot valid flags in flops clear the whole table in the cycle after a tlast
// word, so the next block starts at once. Positions at or past MAX_INSTRS are
// reported with overflow set and position zero, and are not recorded.
`default_nettype none

module register_last_writer_tracker import rlwt_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DATA_IN_W-1:0]  s_tdata,   // [31:0] instruction
    input  wire logic                  s_tlast,   // last_in_block
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [DATA_OUT_W-1:0] m_tdata    // [1:0] op_class, [8:2] dest_slot,
                                                  // [19:9] src1_producer,
                                                  // [30:20] src2_producer,
                                                  // [40:31] position, [41] overflow,
                                                  // [47:42] zero
);

    dec_info_t         dec;
    logic              accept;
    logic              ovf;
    logic              wr_en;
    logic [POS_W-1:0]  cur_pos;
    logic [POS_W-1:0]  rdata1;
    logic [POS_W-1:0]  rdata2;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;

    logic                s1_valid_reg;
    logic [CLASS_W-1:0]  s1_class_reg;
    logic [DEST_W-1:0]   s1_dest_reg;
    logic                s1_use1_reg;
    logic                s1_use2_reg;
    logic [POS_W-1:0]    s1_pos_reg;
    logic                s1_ovf_reg;

    logic [PROD_W-1:0]   src1_prod;
    logic [PROD_W-1:0]   src2_prod;
    logic [POSF_W-1:0]   pos_out;

    rlwt_decode u_decode (
        .instruction (s_tdata),
        .info        (dec)
    );

    // Handshake: the result stage frees when it is empty or being drained
    assign s_tready = !s1_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign ovf     = (cnt_reg >= CNT_W'(MAX_INSTRS));
    assign cur_pos = cnt_reg[POS_W-1:0];
    assign wr_en   = accept && dec.dest_used && !ovf;

    // Position table, one copy per source read port
    rlwt_ram #(
        .WIDTH (POS_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram_rs1 (
        .clk   (clk),
        .we    (wr_en),
        .waddr (dec.dest_slot),
        .wdata (cur_pos),
        .re    (accept),
        .raddr (dec.rs1_slot),
        .rdata (rdata1)
    );

    rlwt_ram #(
        .WIDTH (POS_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram_rs2 (
        .clk   (clk),
        .we    (wr_en),
        .waddr (dec.dest_slot),
        .wdata (cur_pos),
        .re    (accept),
        .raddr (dec.rs2_slot),
        .rdata (rdata2)
    );

    // Valid flags and position counter; end of block clears both
    always_comb
    begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            if (wr_en)
            begin
                valid_next[dec.dest_slot] = 1'b1;
            end
            if (!ovf)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (s_tlast)
            begin
                valid_next = '0;
                cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Result stage payload, aligned with the RAM read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_class_reg <= dec.op_class;
            s1_dest_reg  <= dec.dest_used ? {1'b0, dec.dest_slot} : '1;
            s1_use1_reg  <= dec.rs1_used && valid_reg[dec.rs1_slot];
            s1_use2_reg  <= dec.rs2_used && valid_reg[dec.rs2_slot];
            s1_pos_reg   <= ovf ? '0 : cur_pos;
            s1_ovf_reg   <= ovf;
        end
    end

    assign src1_prod = s1_use1_reg ? prod_field(rdata1) : '1;
    assign src2_prod = s1_use2_reg ? prod_field(rdata2) : '1;
    assign pos_out   = pos_field(s1_pos_reg);

    assign m_tvalid = s1_valid_reg;
    assign m_tdata  = {6'b0, s1_ovf_reg, pos_out, src2_prod, src1_prod,
                       s1_dest_reg, s1_class_reg};

    // Counter saturates at capacity
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_INSTRS))
        else $error("position counter beyond capacity");

    // End of block leaves an empty table and a zero counter
    a_block_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> (valid_reg == '0) && (cnt_reg == '0))
        else $error("table not cleared after last word of block");

    // A known producer always lies earlier in the block
    a_prod1_order: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_use1_reg && !s1_ovf_reg |-> rdata1 < s1_pos_reg)
        else $error("rs1 producer not earlier than consumer");

    a_prod2_order: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_use2_reg && !s1_ovf_reg |-> rdata2 < s1_pos_reg)
        else $error("rs2 producer not earlier than consumer");

    // Overflowed words report position zero
    a_ovf_pos: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ovf_reg |-> s1_pos_reg == '0)
        else $error("overflowed word carries a position");

endmodule

`default_nettype wire

/* sim/register_last_writer_tracker_test.sv */
`timescale 1ns / 100ps

import rlwt_pkg::*;

// Result beat layout, MSB first (matches m_tdata)
typedef struct packed {
    logic [5:0]        pad;
    logic              ovf;
    logic [POSF_W-1:0] position;
    logic [PROD_W-1:0] src2;
    logic [PROD_W-1:0] src1;
    logic [DEST_W-1:0] dest;
    logic [CLASS_W-1:0] op_class;
} trace_result_t;

// Last-writer table predictor and expected-result store
class dependency_scoreboard;
    bit                 writer_known [SLOT_COUNT];
    logic [POS_W-1:0]   writer_pos   [SLOT_COUNT];
    logic [CNT_W-1:0]   block_pos;
    trace_result_t      expected_q [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        overflow_seen;

    function void clear_table();
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            writer_known[i] = 1'b0;
            writer_pos[i]   = '0;
        end
        block_pos = '0;
    endfunction

    function bit fp_arith(logic [6:0] op);
        return op == OPC_OP_FP || op == OPC_FMADD || op == OPC_FMSUB ||
               op == OPC_FNMSUB || op == OPC_FNMADD;
    endfunction

    // Position of the last writer of a slot, all ones when none
    function logic [PROD_W-1:0] producer_of(logic [SLOT_W-1:0] slot);
        logic [PROD_W-1:0] prod;
        prod = '1;
        if (writer_known[slot])
        begin
            prod = '0;
            prod[POS_W-1:0] = writer_pos[slot];
        end
        return prod;
    endfunction

    // Predict the result of one accepted word and update the table
    function void note_instruction(logic [31:0] word, bit last);
        logic [6:0]        op;
        logic [6:0]        f7;
        logic [4:0]        rd;
        logic [4:0]        r1;
        logic [4:0]        r2;
        logic [SLOT_W-1:0] slot;
        bit                ovf;
        bit                fp;
        trace_result_t     res;
        op  = word[6:0];
        rd  = word[11:7];
        r1  = word[19:15];
        r2  = word[24:20];
        f7  = word[31:25];
        ovf = block_pos >= MAX_INSTRS;
        res = '0;
        res.dest = '1;
        res.src1 = '1;
        res.src2 = '1;

        case (op)
            OPC_BRANCH, OPC_JAL, OPC_JALR, OPC_SYSTEM: res.op_class = CLS_CONTROL;
            OPC_STORE, OPC_STORE_FP:                   res.op_class = CLS_STORE;
            OPC_LOAD, OPC_LOAD_FP:                     res.op_class = CLS_LOAD;
            default:                                   res.op_class = CLS_COMPUTE;
        endcase

        // sources are read before the destination is recorded
        if (!(op == OPC_LUI || op == OPC_AUIPC || op == OPC_JAL))
        begin
            fp = fp_arith(op) && f7 != F7_FMV_W_X && f7 != F7_FCVT_S_W;
            slot = {fp, r1};
            res.src1 = producer_of(slot);
        end
        if (op == OPC_OP || op == OPC_STORE || op == OPC_STORE_FP || op == OPC_BRANCH ||
            fp_arith(op))
        begin
            fp = op == OPC_STORE_FP || fp_arith(op);
            slot = {fp, r2};
            res.src2 = producer_of(slot);
        end
        if (!(op == OPC_STORE || op == OPC_STORE_FP || op == OPC_BRANCH))
        begin
            fp = op == OPC_LOAD_FP || fp_arith(op);
            slot = {fp, rd};
            res.dest = {1'b0, slot};
            if (!ovf)
            begin
                writer_known[slot] = 1'b1;
                writer_pos[slot]   = block_pos[POS_W-1:0];
            end
        end

        res.ovf      = ovf;
        res.position = ovf ? '0 : block_pos[POSF_W-1:0];
        if (!ovf)
            block_pos++;
        if (last)
            clear_table();
        expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(trace_result_t got);
        trace_result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: result beat %h with nothing expected", $time, got);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got.ovf)
            overflow_seen++;
        compare_field("op_class", want.op_class, got.op_class);
        compare_field("dest_slot", want.dest, got.dest);
        compare_field("src1_producer", want.src1, got.src1);
        compare_field("src2_producer", want.src2, got.src2);
        compare_field("position", want.position, got.position);
        compare_field("overflow", want.ovf, got.ovf);
        compare_field("pad", want.pad, got.pad);
    endfunction
endclass

module register_last_writer_tracker_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 550;

    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_CADENCE, RDY_SLOW} ready_mode_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_IN_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_OUT_W-1:0] m_tdata;

    dependency_scoreboard score;

    int unsigned burst_left  = 0;
    int unsigned beats_sent  = 0;
    int unsigned blocks_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned ready_left  = 0;
    ready_mode_t ready_mode  = RDY_ALWAYS;
    logic [7:0]  ready_phase = '0;

    logic [6:0] opcode_set [16] = '{OPC_LOAD, OPC_LOAD_FP, OPC_AUIPC, OPC_STORE,
                                    OPC_STORE_FP, OPC_OP, OPC_LUI, OPC_FMADD,
                                    OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD, OPC_OP_FP,
                                    OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    register_last_writer_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Output back-pressure: the mode is redrawn at random times
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = $urandom_range(16, 160);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            RDY_ALWAYS:  m_tready <= 1'b1;
            RDY_RANDOM:  m_tready <= ($urandom_range(0, 1) == 1);
            RDY_CADENCE: m_tready <= (ready_phase % 3) != 0;
            default:     m_tready <= ready_phase[3];
        endcase
    end

    // Result beats are checked on the falling edge before their accepting edge
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            score.check_result(m_tdata);
    end

    // Watchdog on cycles with no beat on either side
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic [31:0] encode(input logic [6:0] op, input logic [4:0] rd,
                                           input logic [4:0] r1, input logic [4:0] r2,
                                           input logic [6:0] f7);
        return {f7, r2, r1, 3'b000, rd, op};
    endfunction

    // Registers drawn mostly from a few hot ones so dependencies form
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 5));
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 9) != 0)
        begin
            w[6:0] = opcode_set[$urandom_range(0, 15)];
            if ($urandom_range(0, 3) != 0)
            begin
                w[11:7]  = pick_reg();
                w[19:15] = pick_reg();
                w[24:20] = pick_reg();
            end
            // integer-source FP forms
            if ((w[6:0] inside {OPC_OP_FP, OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD}) &&
                $urandom_range(0, 2) == 0)
                w[31:25] = ($urandom_range(0, 1) == 1) ? F7_FMV_W_X : F7_FCVT_S_W;
        end
        return w;
    endfunction

    // Drive one beat; caller is at a rising edge, returns at the accepting edge
    task automatic send_word(input logic [31:0] word, input bit last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(50, 200);
            end
            else
            begin
                gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = $urandom_range(1, 24);
            end
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tlast  <= last;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        score.note_instruction(word, last);
        beats_sent++;
        if (last)
            blocks_sent++;
    endtask

    task automatic send_block(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_word(random_word(), i == len - 1);
    endtask

    initial
    begin
        int unsigned target;
        score = new();
        score.clear_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every opcode, integer/FP slot selection
        send_word(32'h0000_0000, 1'b0);                                 // x0 written
        send_word(32'hFFFF_FFFF, 1'b0);                                 // unknown opcode
        send_word(encode(OPC_OP, 5'd5, 5'd0, 5'd31, 7'h00), 1'b0);
        send_word(encode(OPC_OP, 5'd5, 5'd5, 5'd5, 7'h00), 1'b0);       // reads own dest
        send_word(encode(OPC_LUI, 5'd6, 5'd5, 5'd5, 7'h00), 1'b0);
        send_word(encode(OPC_AUIPC, 5'd7, 5'd5, 5'd5, 7'h00), 1'b0);
        send_word(encode(OPC_JAL, 5'd1, 5'd5, 5'd5, 7'h00), 1'b0);
        send_word(encode(OPC_JALR, 5'd2, 5'd6, 5'd5, 7'h00), 1'b0);
        send_word(encode(OPC_BRANCH, 5'd9, 5'd5, 5'd6, 7'h00), 1'b0);
        send_word(encode(OPC_LOAD, 5'd8, 5'd7, 5'd5, 7'h00), 1'b0);
        send_word(encode(OPC_LOAD_FP, 5'd3, 5'd8, 5'd5, 7'h00), 1'b0);
        send_word(encode(OPC_STORE, 5'd0, 5'd2, 5'd8, 7'h00), 1'b0);
        send_word(encode(OPC_STORE_FP, 5'd0, 5'd2, 5'd3, 7'h00), 1'b0);
        send_word(encode(OPC_OP_FP, 5'd4, 5'd3, 5'd3, 7'h00), 1'b0);
        send_word(encode(OPC_OP_FP, 5'd5, 5'd8, 5'd0, F7_FMV_W_X), 1'b0);
        send_word(encode(OPC_OP_FP, 5'd6, 5'd5, 5'd0, F7_FCVT_S_W), 1'b0);
        send_word(encode(OPC_FMADD, 5'd7, 5'd4, 5'd5, 7'h00), 1'b0);
        send_word(encode(OPC_FMSUB, 5'd8, 5'd6, 5'd7, 7'h00), 1'b0);
        send_word(encode(OPC_FNMSUB, 5'd9, 5'd8, 5'd4, 7'h00), 1'b0);
        send_word(encode(OPC_FNMADD, 5'd10, 5'd9, 5'd9, 7'h00), 1'b0);
        send_word(encode(OPC_SYSTEM, 5'd9, 5'd9, 5'd0, 7'h00), 1'b0);
        send_word(encode(OPC_OP, 5'd0, 5'd0, 5'd0, 7'h00), 1'b1);       // end of block
        send_word(encode(OPC_OP, 5'd1, 5'd5, 5'd0, 7'h00), 1'b0);       // table cleared
        send_word(encode(OPC_LOAD_FP, 5'd3, 5'd1, 5'd0, 7'h00), 1'b1);

        // Random blocks of mostly decodable words
        target = beats_sent + RANDOM_WORDS;
        while (beats_sent < target)
            send_block($urandom_range(1, 40));

        // One block that runs past capacity, then short ones to see it cleared
        send_block(MAX_INSTRS + $urandom_range(1, 24));
        repeat (3) send_block($urandom_range(1, 12));
        s_tvalid <= 1'b0;

        // Drain and let any stray beat show up
        while (score.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (score.expected_q.size() != 0)
            score.mismatches++;

        $display("Sent %0d instruction beats in %0d blocks; checked %0d results, %0d past capacity.",
                 beats_sent, blocks_sent, score.checked, score.overflow_seen);
        $display("Mismatches: %0d", score.mismatches);
        if (score.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
